// ----- rtl/core/counter_priority_task_scheduler_core_macros.svh -----
// Assertion macros shared by the scheduler RTL.
`ifndef COUNTER_PRIORITY_TASK_SCHEDULER_CORE_MACROS_SVH
`define COUNTER_PRIORITY_TASK_SCHEDULER_CORE_MACROS_SVH

// Same-cycle implication.
`define CPTS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler assertion failed");

// Next-cycle implication.
`define CPTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler assertion failed");

`endif

// ----- rtl/core/cpts_pkg.sv -----
// Types and constants shared by the counter-priority task scheduler.
`timescale 1ns / 1ps
package cpts_pkg;

   localparam int unsigned NUM_TASKS_DEF = 16;
   localparam int unsigned SLOT_W        = 4;
   localparam int unsigned PRIO_W        = 7;
   localparam int unsigned COUNT_W       = 8;
   localparam int unsigned KIND_W        = 2;

   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_READY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SCHED = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [SLOT_W-1:0]  slot;
      logic               present;
      logic               ready_req;
      logic [PRIO_W-1:0]  priority_req;
      logic [COUNT_W-1:0] slice;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]  chosen;
      logic               chose_idle;
      logic [COUNT_W-1:0] chosen_count;
      logic               refilled;
      logic               switched;
      logic               stuck;
   } rsp_type;

   typedef struct packed {
      logic               full;
      logic               present;
      logic               ready_req;
      logic [PRIO_W-1:0]  priority_req;
      logic [COUNT_W-1:0] slice;
   } wr_type;

   typedef struct packed {
      logic               live;
      logic               refill;
      logic               found;
      logic [SLOT_W-1:0]  best_idx;
      logic [COUNT_W-1:0] best_cnt;
      logic [COUNT_W-1:0] idle_cnt;
   } scan_type;

endpackage

// ----- rtl/core/cpts_cell.sv -----
// One task slot: holds its state and passes the scan record to the next slot.
`timescale 1ns / 1ps
module cpts_cell #(
   parameter int unsigned IDX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  cpts_pkg::wr_type  wr,
   input  logic              idle_hit,
   input  cpts_pkg::scan_type scan_in,
   output cpts_pkg::scan_type scan_out
);
   import cpts_pkg::*;

   logic               present_ff, present_in;
   logic               ready_ff, ready_in;
   logic [PRIO_W-1:0]  priority_ff, priority_in;
   logic [COUNT_W-1:0] counter_ff, counter_in;
   scan_type           scan_ff, scan_in_nx;
   logic [COUNT_W-1:0] refill_cnt;
   logic [COUNT_W-1:0] eff_cnt;
   logic               do_refill;
   logic               cand;

   always_comb begin
      refill_cnt = {1'b0, counter_ff[COUNT_W-1:1]} + {1'b0, priority_ff};
      do_refill  = scan_in.live && scan_in.refill && present_ff;
      eff_cnt    = do_refill ? refill_cnt : counter_ff;
      cand       = present_ff && ready_ff && !idle_hit;

      present_in  = present_ff;
      ready_in    = ready_ff;
      priority_in = priority_ff;
      counter_in  = do_refill ? refill_cnt : counter_ff;
      if (wr_en) begin
         ready_in = wr.ready_req;
         if (wr.full) begin
            present_in  = wr.present;
            priority_in = wr.priority_req;
            counter_in  = wr.slice;
         end
      end

      scan_in_nx = scan_in;
      if (scan_in.live) begin
         if (idle_hit) begin
            scan_in_nx.idle_cnt = eff_cnt;
         end
         if (cand && (!scan_in.found || eff_cnt >= scan_in.best_cnt)) begin
            scan_in_nx.found    = 1'b1;
            scan_in_nx.best_idx = SLOT_W'(IDX);
            scan_in_nx.best_cnt = eff_cnt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff  <= 1'b0;
         ready_ff    <= 1'b0;
         priority_ff <= '0;
         counter_ff  <= '0;
         scan_ff     <= '0;
      end else begin
         present_ff  <= present_in;
         ready_ff    <= ready_in;
         priority_ff <= priority_in;
         counter_ff  <= counter_in;
         scan_ff     <= scan_in_nx;
      end
   end

   assign scan_out = scan_ff;

endmodule

// ----- rtl/core/counter_priority_task_scheduler_core.sv -----
// Top level of the counter-priority task scheduler.
// Usage:
//  - req channel (req_valid/req_ready/req_data) takes slot writes, ready-flag
//    updates and schedule requests; rsp channel returns one beat per schedule.
//  - csr channel writes the idle slot number; csr_ready is always high.
//  - A slot write or ready update is registered in its slot cell; writes give no rsp beat.
//  - A schedule request sends a scan record down a chain of NUM_TASKS slot
//    cells, one cell per cycle. The result beat follows one pass of the
//    chain, or two passes when the counters are refilled, since the refill
//    and the second pick share one more pass of the chain.
//  - req_ready is high only between schedule requests; the next request is
//    taken while a finished result still waits in the rsp output register.
//  - If rsp_ready stays low, the block holds the beat, and a second finished
//    result waits inside until the output register drains.
//  - Synchronous reset clears every slot, the idle slot and the running task.
`timescale 1ns / 1ps
`include "counter_priority_task_scheduler_core_macros.svh"
module counter_priority_task_scheduler_core #(
   parameter int unsigned NUM_TASKS = cpts_pkg::NUM_TASKS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  cpts_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output cpts_pkg::rsp_type           rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [cpts_pkg::SLOT_W-1:0] csr_data
);
   import cpts_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [SLOT_W-1:0]  idle_slot_ff, idle_slot_in;
   logic [SLOT_W-1:0]  current_ff, current_in;
   rsp_type            pend_ff, pend_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   scan_type           chain [NUM_TASKS+1];
   scan_type           head;
   scan_type           tail;
   logic [NUM_TASKS-1:0] wr_sel;
   logic [NUM_TASKS-1:0] idle_hit;
   wr_type             wr;
   logic               req_fire;
   logic               is_write;
   logic               need_refill;
   logic               launch;
   rsp_type            res;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign is_write  = (req_data.kind == KIND_WRITE) || (req_data.kind == KIND_READY);

   assign wr.full         = (req_data.kind == KIND_WRITE);
   assign wr.present      = req_data.present;
   assign wr.ready_req    = req_data.ready_req;
   assign wr.priority_req = req_data.priority_req;
   assign wr.slice        = req_data.slice;

   assign tail        = chain[NUM_TASKS];
   assign need_refill = tail.live && tail.found && (tail.best_cnt == '0) && !tail.refill;
   assign launch      = (req_fire && (req_data.kind == KIND_SCHED)) ||
                        ((state_ff == ST_SCAN) && need_refill);

   always_comb begin
      head        = '0;
      head.live   = launch;
      head.refill = (state_ff == ST_SCAN);
   end

   assign chain[0] = head;

   for (genvar g = 0; g < NUM_TASKS; g++) begin : g_cell
      assign wr_sel[g]   = req_fire && is_write && (32'(req_data.slot) == g);
      assign idle_hit[g] = (32'(idle_slot_ff) == g);

      cpts_cell #(
         .IDX(g)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .wr_en   (wr_sel[g]),
         .wr      (wr),
         .idle_hit(idle_hit[g]),
         .scan_in (chain[g]),
         .scan_out(chain[g+1])
      );
   end

   always_comb begin
      res.chosen       = tail.found ? tail.best_idx : idle_slot_ff;
      res.chose_idle   = !tail.found;
      res.chosen_count = tail.found ? tail.best_cnt : tail.idle_cnt;
      res.refilled     = tail.refill;
      res.stuck        = tail.refill && tail.found && (tail.best_cnt == '0);
      res.switched     = (res.chosen != current_ff);
   end

   always_comb begin
      state_in     = state_ff;
      idle_slot_in = (csr_valid && csr_ready) ? csr_data : idle_slot_ff;
      current_in   = current_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_data.kind == KIND_SCHED)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (tail.live && !need_refill) begin
               pend_in    = res;
               current_in = res.chosen;
               state_in   = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idle_slot_ff <= '0;
         current_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idle_slot_ff <= idle_slot_in;
         current_ff   <= current_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `CPTS_ASSERT_NEXT(a_launch_moves, clock, reset, chain[0].live, chain[1].live)
   `CPTS_ASSERT_IMPL(a_tail_in_scan, clock, reset, tail.live, state_ff == ST_SCAN)
   `CPTS_ASSERT_IMPL(a_stuck_refilled, clock, reset, rsp_valid_ff, !rsp_ff.stuck || rsp_ff.refilled)
   `CPTS_ASSERT_IMPL(a_idle_no_refill, clock, reset, rsp_valid_ff && rsp_ff.chose_idle, !rsp_ff.refilled && !rsp_ff.stuck)

endmodule

// ----- tb/sv/counter_priority_task_scheduler_core_tb.sv -----
`timescale 1ns / 1ps
// Testbench for the counter-priority task scheduler core: table predictor, directed and random traffic.
module counter_priority_task_scheduler_core_tb;
   import cpts_pkg::*;

   localparam int unsigned TASK_COUNT = NUM_TASKS_DEF;
   localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
   localparam int SETTLE_CYCLES = 2 * TASK_COUNT + 10;
   localparam int PHASE_ITEMS = 217;
   localparam int LONG_HOLD = 400;

   class sched_scoreboard;
      bit                task_on [TASK_COUNT];
      bit                task_rdy [TASK_COUNT];
      bit [PRIO_W-1:0]   task_prio [TASK_COUNT];
      bit [COUNT_W-1:0]  task_cnt [TASK_COUNT];
      bit [SLOT_W-1:0]   running;
      bit [SLOT_W-1:0]   idle_slot;
      rsp_type           expected_picks[$];
      int                errors;

      function new();
         running = '0;
         idle_slot = '0;
         errors = 0;
      endfunction

      function void set_idle(input logic [SLOT_W-1:0] slot_no);
         idle_slot = slot_no;
      endfunction

      function int best_slot(output bit [COUNT_W-1:0] best);
         int cand;
         cand = -1;
         best = '0;
         for (int i = 0; i < TASK_COUNT; i++) begin
            if (i == idle_slot || !task_on[i] || !task_rdy[i])
               continue;
            if (cand < 0 || task_cnt[i] >= best) begin
               cand = i;
               best = task_cnt[i];
            end
         end
         return cand;
      endfunction

      function rsp_type predict_pick();
         rsp_type pick;
         bit [COUNT_W-1:0] best;
         int cand;
         pick = '0;
         cand = best_slot(best);
         if (cand >= 0 && best == 0) begin
            for (int i = 0; i < TASK_COUNT; i++)
               if (task_on[i])
                  task_cnt[i] = (task_cnt[i] >> 1) + COUNT_W'(task_prio[i]);
            pick.refilled = 1'b1;
            cand = best_slot(best);
            if (cand >= 0 && best == 0)
               pick.stuck = 1'b1;
         end
         if (cand < 0) begin
            pick.chose_idle = 1'b1;
            pick.chosen = idle_slot;
         end else begin
            pick.chosen = SLOT_W'(cand);
         end
         pick.chosen_count = (pick.chosen < TASK_COUNT) ? task_cnt[pick.chosen] : '0;
         pick.switched = (pick.chosen != running);
         running = pick.chosen;
         return pick;
      endfunction

      function void note_req(input req_type item);
         case (item.kind)
            KIND_WRITE, KIND_READY: begin
               task_rdy[item.slot] = item.ready_req;
               if (item.kind == KIND_WRITE) begin
                  task_on[item.slot] = item.present;
                  task_prio[item.slot] = item.priority_req;
                  task_cnt[item.slot] = item.slice;
               end
            end
            KIND_SCHED: expected_picks.push_back(predict_pick());
            default: ;
         endcase
      endfunction

      function void check_field(input string name, input int unsigned want,
                                input int unsigned got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         end
      endfunction

      function void check_rsp(input rsp_type got);
         rsp_type want;
         if (expected_picks.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat, expected none, got %p", $time, got);
            return;
         end
         want = expected_picks.pop_front();
         check_field("chosen", want.chosen, got.chosen);
         check_field("chose_idle", want.chose_idle, got.chose_idle);
         check_field("chosen_count", want.chosen_count, got.chosen_count);
         check_field("refilled", want.refilled, got.refilled);
         check_field("switched", want.switched, got.switched);
         check_field("stuck", want.stuck, got.stuck);
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_type             rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [SLOT_W-1:0]   csr_data = '0;

   int send_gap = 9;
   int recv_gap = 65;
   int hold_left = 0;
   int beats_taken = 0;
   bit held_once = 1'b0;

   sched_scoreboard board = new();

   counter_priority_task_scheduler_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("counter_priority_task_scheduler_core_tb NOT OK");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            board.check_rsp(rsp_data);
         if (req_valid && req_ready)
            board.note_req(req_data);
         if (csr_valid && csr_ready)
            board.set_idle(csr_data);
      end
   end

   // hold off once for a long stretch so the block fills and stalls its input
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            beats_taken <= beats_taken + 1;
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
         end else if (!held_once && beats_taken == 40) begin
            held_once <= 1'b1;
            hold_left <= LONG_HOLD;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_gap);
         end
      end
   end

   function automatic req_type make_item(input logic [KIND_W-1:0] kind,
                                         input int slot_no, input bit on, input bit rdy,
                                         input int prio, input int slice_val);
      req_type item;
      item.kind = kind;
      item.slot = SLOT_W'(slot_no);
      item.present = on;
      item.ready_req = rdy;
      item.priority_req = PRIO_W'(prio);
      item.slice = COUNT_W'(slice_val);
      return item;
   endfunction

   function automatic req_type random_item(input bit lean);
      req_type item;
      int pick;
      pick = $urandom_range(99);
      item.kind = (pick < 30) ? KIND_WRITE : (pick < 55) ? KIND_READY :
                  (pick < 95) ? KIND_SCHED : KIND_NONE;
      item.slot = SLOT_W'($urandom_range(TASK_COUNT - 1));
      item.present = ($urandom_range(9) != 0);
      item.ready_req = ($urandom_range(9) < 7);
      pick = $urandom_range(99);
      if (lean)
         item.priority_req = (pick < 60) ? '0 : PRIO_W'($urandom_range(127));
      else
         item.priority_req = (pick < 10) ? '0 : (pick < 30) ? PRIO_W'($urandom_range(3)) :
                             PRIO_W'($urandom_range(127));
      pick = $urandom_range(99);
      if (lean)
         item.slice = (pick < 50) ? COUNT_W'($urandom_range(1)) : COUNT_W'($urandom_range(255));
      else
         item.slice = (pick < 20) ? '0 : COUNT_W'($urandom_range(255));
      return item;
   endfunction

   task automatic send_req(input req_type item);
      while ($urandom_range(99) < send_gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   task automatic write_idle(input logic [SLOT_W-1:0] slot_no);
      csr_valid <= 1'b1;
      csr_data <= slot_no;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.expected_picks.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [SLOT_W-1:0] idle_vals [6];
      req_type item;
      int sent;
      idle_vals[0] = 4'd15;
      idle_vals[1] = 4'd0;
      idle_vals[2] = 4'd9;
      idle_vals[3] = SLOT_W'($urandom_range(TASK_COUNT - 1));
      idle_vals[4] = 4'd15;
      idle_vals[5] = SLOT_W'($urandom_range(TASK_COUNT - 1));

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      write_idle(4'd0);

      send_req(make_item(KIND_SCHED, 0, 0, 0, 0, 0));
      send_req(make_item(KIND_WRITE, 0, 1, 1, 127, 255));
      send_req(make_item(KIND_SCHED, 15, 1, 1, 127, 255));
      send_req(make_item(KIND_READY, 5, 0, 1, 0, 0));
      send_req(make_item(KIND_SCHED, 5, 0, 0, 0, 0));
      send_req(make_item(KIND_WRITE, 15, 1, 1, 127, 255));
      send_req(make_item(KIND_WRITE, 3, 1, 1, 0, 255));
      send_req(make_item(KIND_SCHED, 0, 0, 0, 0, 0));
      send_req(make_item(KIND_READY, 15, 1, 0, 127, 255));
      send_req(make_item(KIND_SCHED, 0, 0, 0, 0, 0));
      send_req(make_item(KIND_WRITE, 3, 1, 1, 0, 0));
      send_req(make_item(KIND_WRITE, 9, 1, 1, 10, 0));
      send_req(make_item(KIND_SCHED, 0, 0, 0, 0, 0));
      send_req(make_item(KIND_WRITE, 9, 1, 1, 0, 0));
      send_req(make_item(KIND_SCHED, 0, 0, 0, 0, 0));
      send_req(make_item(KIND_NONE, 15, 1, 1, 127, 255));
      send_req(make_item(KIND_WRITE, 12, 0, 1, 127, 255));
      send_req(make_item(KIND_SCHED, 0, 0, 0, 0, 0));
      send_req(make_item(KIND_WRITE, 15, 1, 1, 127, 128));
      send_req(make_item(KIND_SCHED, 15, 1, 1, 127, 255));
      send_req(make_item(KIND_READY, 15, 0, 0, 0, 0));
      send_req(make_item(KIND_SCHED, 0, 0, 0, 0, 0));
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase / 2)
            0: begin send_gap = 9;  recv_gap = 65; end
            1: begin send_gap = 65; recv_gap = 9;  end
            default: begin send_gap = 0; recv_gap = 0; end
         endcase
         write_idle(idle_vals[phase]);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            item = random_item(phase[0]);
            send_req(item);
            if (item.kind != KIND_NONE)
               sent++;
         end
         drain();
      end

      if (board.errors == 0 && board.expected_picks.size() == 0)
         $display("counter_priority_task_scheduler_core_tb OK");
      else
         $display("counter_priority_task_scheduler_core_tb NOT OK");
      $finish;
   end

endmodule
